// ===== hdl/quarter_rate_mix_resample_magnitude_unit_assert.svh =====
// ----------------------------------------------------------------------------
// quarter rate mix resample magnitude unit - assertion macros
// Shared concurrent check macros. Clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUARTER_RATE_MIX_RESAMPLE_MAGNITUDE_UNIT_ASSERT_SVH
`define QUARTER_RATE_MIX_RESAMPLE_MAGNITUDE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define QRMRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define QRMRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/qrmrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrmrm_pkg
// Shared constants and types for the quarter rate mix resample magnitude unit.
// ----------------------------------------------------------------------------
package qrmrm_pkg;

    // default configuration
    localparam int DEF_INTERP_FACTOR = 25;
    localparam int DEF_DECIM_FACTOR  = 384;
    localparam int DEF_SAMPLE_WIDTH  = 16;

    // result field
    localparam int MAG_WIDTH = 14;
    localparam logic [MAG_WIDTH-1:0] MAG_MAX = '1;

    // state of a serial arithmetic stage
    typedef enum logic [1:0] {
        US_IDLE = 2'b01,
        US_RUN  = 2'b10
    } t_unit_st;

endpackage

// ===== hdl/qrmrm_interp.sv =====
// ----------------------------------------------------------------------------
// qrmrm_interp
// Serial linear interpolation: N = L*D + (D - P)*f, one bit of f per cycle,
// then the absolute value of both components.
// ----------------------------------------------------------------------------
module qrmrm_interp #(
    parameter int INTERP_FACTOR = qrmrm_pkg::DEF_INTERP_FACTOR,
    parameter int SAMPLE_WIDTH  = qrmrm_pkg::DEF_SAMPLE_WIDTH,
    localparam int FW = $clog2(INTERP_FACTOR + 1),
    localparam int NW = SAMPLE_WIDTH + $clog2(INTERP_FACTOR) + 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SAMPLE_WIDTH:0] i_d_i,
    input  logic signed [SAMPLE_WIDTH:0] i_d_q,
    input  logic signed [SAMPLE_WIDTH:0] i_p_i,
    input  logic signed [SAMPLE_WIDTH:0] i_p_q,
    input  logic [FW-1:0]            i_frac,
    output logic                     o_done,
    output logic [NW-1:0]            o_abs_i,
    output logic [NW-1:0]            o_abs_q
);
    import qrmrm_pkg::*;

    localparam int CW = $clog2(FW + 1);
    localparam logic signed [NW-1:0] L_CONST = NW'(INTERP_FACTOR);

    t_unit_st             r_state;
    logic                 r_done;
    logic signed [NW-1:0] r_acc_i, r_acc_q;
    logic signed [NW-1:0] r_add_i, r_add_q;
    logic [FW-1:0]        r_frac;
    logic [CW-1:0]        r_cnt;
    logic [NW-1:0]        r_abs_i, r_abs_q;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= US_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                US_IDLE: begin
                    if (i_start) begin
                        r_state <= US_RUN;
                    end
                end
                US_RUN: begin
                    if (r_cnt == CW'(FW)) begin
                        r_state <= US_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= US_IDLE;
            endcase
        end
    end

    // shift-add datapath, fraction bits consumed lsb first
    always_ff @(posedge i_clk) begin
        if (r_state == US_IDLE && i_start) begin
            r_acc_i <= L_CONST * NW'(i_d_i);
            r_acc_q <= L_CONST * NW'(i_d_q);
            r_add_i <= NW'(i_d_i) - NW'(i_p_i);
            r_add_q <= NW'(i_d_q) - NW'(i_p_q);
            r_frac  <= i_frac;
            r_cnt   <= '0;
        end else if (r_state == US_RUN) begin
            if (r_frac[0]) begin
                r_acc_i <= r_acc_i + r_add_i;
                r_acc_q <= r_acc_q + r_add_q;
            end
            r_add_i <= r_add_i <<< 1;
            r_add_q <= r_add_q <<< 1;
            r_frac  <= r_frac >> 1;
            r_cnt   <= r_cnt + 1'b1;
            // fraction fully consumed, take absolute values
            if (r_cnt == CW'(FW)) begin
                r_abs_i <= r_acc_i[NW-1] ? NW'(-r_acc_i) : NW'(r_acc_i);
                r_abs_q <= r_acc_q[NW-1] ? NW'(-r_acc_q) : NW'(r_acc_q);
            end
        end
    end

    assign o_done  = r_done;
    assign o_abs_i = r_abs_i;
    assign o_abs_q = r_abs_q;

endmodule

// ===== hdl/qrmrm_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrmrm_sqrt
// Serial magnitude: shift-add squares of both components, then a restoring
// square root that takes two bits of the sum per cycle.
// ----------------------------------------------------------------------------
module qrmrm_sqrt #(
    parameter int AW = 24,
    localparam int RW = AW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_a_i,
    input  logic [AW-1:0] i_a_q,
    output logic          o_done,
    output logic [RW-1:0] o_root
);
    import qrmrm_pkg::*;

    localparam int SW   = 2 * RW;
    localparam int RMW  = RW + 2;
    localparam int CNTW = $clog2(RW + 1);

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_MUL  = 3'b010,
        SQ_ROOT = 3'b100
    } t_sq_st;

    t_sq_st            r_state;
    logic              r_done;
    logic              r_sel;
    logic [CNTW-1:0]   r_cnt;
    logic [SW-1:0]     r_mcand;
    logic [AW-1:0]     r_mplier;
    logic [AW-1:0]     r_b_q;
    logic [SW-1:0]     r_acc;
    logic [RMW-1:0]    r_rem;
    logic [RW-1:0]     r_root;

    logic [RMW+1:0]    w_rem_sh;
    logic [RMW+1:0]    w_trial;
    logic              w_fit;

    // root step: bring down two bits, try (root << 2) | 1
    assign w_rem_sh = {r_rem, r_acc[SW-1:SW-2]};
    assign w_trial  = (RMW + 2)'({r_root, 2'b01});
    assign w_fit    = (w_rem_sh >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                SQ_IDLE: begin
                    if (i_start) begin
                        r_state <= SQ_MUL;
                    end
                end
                SQ_MUL: begin
                    if (r_sel && r_cnt == CNTW'(AW - 1)) begin
                        r_state <= SQ_ROOT;
                    end
                end
                SQ_ROOT: begin
                    if (r_cnt == CNTW'(RW - 1)) begin
                        r_state <= SQ_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= SQ_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    r_sel    <= 1'b0;
                    r_cnt    <= '0;
                    r_mcand  <= SW'(i_a_i);
                    r_mplier <= i_a_i;
                    r_b_q    <= i_a_q;
                    r_acc    <= '0;
                end
            end
            SQ_MUL: begin
                // one partial product per cycle
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                if (r_cnt == CNTW'(AW - 1)) begin
                    r_cnt    <= '0;
                    r_sel    <= 1'b1;
                    r_mcand  <= SW'(r_b_q);
                    r_mplier <= r_b_q;
                    r_rem    <= '0;
                    r_root   <= '0;
                end else begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            SQ_ROOT: begin
                r_acc <= r_acc << 2;
                r_cnt <= r_cnt + 1'b1;
                if (w_fit) begin
                    r_rem  <= RMW'(w_rem_sh - w_trial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= RMW'(w_rem_sh);
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/qrmrm_div.sv =====
// ----------------------------------------------------------------------------
// qrmrm_div
// Restoring division by a fixed divisor, one quotient bit per cycle,
// with saturation to the result field.
// ----------------------------------------------------------------------------
module qrmrm_div #(
    parameter int NUM_W   = 25,
    parameter int DIVISOR = 375
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [NUM_W-1:0]                i_num,
    output logic                            o_done,
    output logic [qrmrm_pkg::MAG_WIDTH-1:0] o_mag
);
    import qrmrm_pkg::*;

    localparam int CW   = $clog2(DIVISOR + 1);
    localparam int CNTW = $clog2(NUM_W + 1);
    localparam int XW   = (NUM_W > MAG_WIDTH) ? NUM_W : MAG_WIDTH;
    localparam logic [CW:0] DIV_C = (CW + 1)'(DIVISOR);

    t_unit_st             r_state;
    logic                 r_done;
    logic [NUM_W-1:0]     r_num;
    logic [CW-1:0]        r_rem;
    logic [CNTW-1:0]      r_cnt;
    logic [MAG_WIDTH-1:0] r_mag;

    logic [CW:0]          w_part;
    logic                 w_ge;

    // partial remainder with the next dividend bit
    assign w_part = {r_rem, r_num[NUM_W-1]};
    assign w_ge   = (w_part >= DIV_C);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= US_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                US_IDLE: begin
                    if (i_start) begin
                        r_state <= US_RUN;
                    end
                end
                US_RUN: begin
                    if (r_cnt == CNTW'(NUM_W)) begin
                        r_state <= US_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= US_IDLE;
            endcase
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (r_state == US_IDLE && i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == US_RUN) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNTW'(NUM_W)) begin
                r_mag <= (XW'(r_num) > XW'(MAG_MAX)) ? MAG_MAX : MAG_WIDTH'(r_num);
            end else begin
                r_rem <= w_ge ? CW'(w_part - DIV_C) : CW'(w_part);
                r_num <= {r_num[NUM_W-2:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;

endmodule

// ===== hdl/quarter_rate_mix_resample_magnitude_unit.sv =====
// ----------------------------------------------------------------------------
// quarter_rate_mix_resample_magnitude_unit
// Quarter-rate mixer, L/M linear interpolating resampler and magnitude / S.
// ----------------------------------------------------------------------------
// channel  handshake                  payload
// input    i_in_valid / o_in_stall    i_sample_i, i_sample_q
// output   o_out_valid / i_out_stall  o_magnitude
//
// An input that produces no result is never stalled and is taken back to back.
// An input that produces a result runs a serial chain: the interpolation,
// the bit-serial squaring, the two-bits-per-cycle root and the
// one-bit-per-cycle divide.
// While that chain runs, inputs that produce no result are still taken.
// Reset clears control and sequencing state at once, not the datapath; there is no clearing pass.
// A stalled result sits in the output register and does not block input.
// ----------------------------------------------------------------------------
`include "quarter_rate_mix_resample_magnitude_unit_assert.svh"

module quarter_rate_mix_resample_magnitude_unit #(
    parameter int INTERP_FACTOR = qrmrm_pkg::DEF_INTERP_FACTOR,
    parameter int DECIM_FACTOR  = qrmrm_pkg::DEF_DECIM_FACTOR,
    parameter int SAMPLE_WIDTH  = qrmrm_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_q,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [qrmrm_pkg::MAG_WIDTH-1:0] o_magnitude
);
    import qrmrm_pkg::*;

    localparam int W       = SAMPLE_WIDTH;
    localparam int SCALE   = (DECIM_FACTOR / INTERP_FACTOR == 0) ? 1
                             : DECIM_FACTOR / INTERP_FACTOR;
    localparam int DIVISOR = INTERP_FACTOR * SCALE;
    localparam int FW      = $clog2(INTERP_FACTOR + 1);
    localparam int KW      = $clog2(INTERP_FACTOR + 1);
    localparam int NW      = W + $clog2(INTERP_FACTOR) + 3;
    localparam int RW      = NW + 1;
    localparam int PW      = $clog2(DECIM_FACTOR);
    localparam int NPW     = $clog2(DECIM_FACTOR + 1);

    localparam logic [NPW-1:0] POS_STEP  = NPW'(DECIM_FACTOR / INTERP_FACTOR);
    localparam logic [FW:0]    FRAC_STEP = (FW + 1)'(DECIM_FACTOR % INTERP_FACTOR);
    localparam logic [FW:0]    FRAC_WRAP = (FW + 1)'(INTERP_FACTOR);
    localparam logic [KW-1:0]  K_LAST    = KW'(INTERP_FACTOR);
    localparam logic [PW-1:0]  POS_LAST  = PW'(DECIM_FACTOR - 1);

    // rotation codes of the mixer
    typedef enum logic [1:0] {
        MIX_PASS  = 2'd0,
        MIX_NEG_J = 2'd1,
        MIX_NEG   = 2'd2,
        MIX_POS_J = 2'd3
    } t_mix_ph;

    typedef enum logic [2:0] {
        TS_IDLE = 3'b001,
        TS_CALC = 3'b010,
        TS_HOLD = 3'b100
    } t_top_st;

    t_top_st                r_state;
    t_mix_ph                r_phase;
    logic signed [W-1:0]    r_prev_i, r_prev_q;
    logic [PW-1:0]          r_in_pos;
    logic [KW-1:0]          r_out_idx;
    logic [NPW-1:0]         r_next_pos;
    logic [FW-1:0]          r_frac;
    logic                   r_out_valid;
    logic [MAG_WIDTH-1:0]   r_mag;

    logic [NPW-1:0]         n_next_pos;
    logic [FW-1:0]          n_frac;
    logic [FW:0]            w_frac_sum;

    logic                   w_emit;
    logic                   w_in_fire;
    logic                   w_start;
    logic                   w_out_load;
    logic signed [W:0]      w_d_i, w_d_q, w_p_i, w_p_q;
    logic                   w_interp_done, w_sqrt_done, w_div_done;
    logic [NW-1:0]          w_abs_i, w_abs_q;
    logic [RW-1:0]          w_root;
    logic [MAG_WIDTH-1:0]   w_div_mag;

    // rotate one sample by the given quarter turn
    function automatic logic [2*W+1:0] mix_pair(input t_mix_ph ph,
                                                input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        logic signed [W:0] xa, xb, yi, yq;
        xa = (W + 1)'(a);
        xb = (W + 1)'(b);
        unique case (ph)
            MIX_PASS:  begin yi = xa;  yq = xb;  end
            MIX_NEG_J: begin yi = xb;  yq = -xa; end
            MIX_NEG:   begin yi = -xa; yq = -xb; end
            MIX_POS_J: begin yi = -xb; yq = xa;  end
            default:   begin yi = xa;  yq = xb;  end
        endcase
        return {yi, yq};
    endfunction

    // current and previous mixed samples
    assign {w_d_i, w_d_q} = mix_pair(r_phase, i_sample_i, i_sample_q);
    assign {w_p_i, w_p_q} = mix_pair(t_mix_ph'(r_phase - 2'd1), r_prev_i, r_prev_q);

    // does the next input carry an output, from state alone
    assign w_emit     = (r_out_idx < K_LAST) && (r_next_pos <= NPW'(r_in_pos));
    assign o_in_stall = (r_state != TS_IDLE) && w_emit;
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_start    = w_in_fire && w_emit;
    assign w_out_load = (r_state == TS_HOLD) && (!r_out_valid || !i_out_stall);

    // position of the following output: advance by M/L in steps of 1/L
    always_comb begin
        w_frac_sum = {1'b0, r_frac} + FRAC_STEP;
        if (w_frac_sum >= FRAC_WRAP) begin
            n_frac     = FW'(w_frac_sum - FRAC_WRAP);
            n_next_pos = r_next_pos + POS_STEP + 1'b1;
        end else begin
            n_frac     = FW'(w_frac_sum);
            n_next_pos = r_next_pos + POS_STEP;
        end
    end

    // sample sequencing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= MIX_PASS;
            r_prev_i   <= '0;
            r_prev_q   <= '0;
            r_in_pos   <= '0;
            r_out_idx  <= '0;
            r_next_pos <= '0;
            r_frac     <= '0;
        end else if (w_in_fire) begin
            r_prev_i <= i_sample_i;
            r_prev_q <= i_sample_q;
            r_phase  <= t_mix_ph'(r_phase + 2'd1);
            if (r_in_pos == POS_LAST) begin
                r_in_pos   <= '0;
                r_out_idx  <= '0;
                r_next_pos <= '0;
                r_frac     <= '0;
            end else begin
                r_in_pos <= r_in_pos + 1'b1;
                if (w_emit) begin
                    r_out_idx  <= r_out_idx + 1'b1;
                    r_next_pos <= n_next_pos;
                    r_frac     <= n_frac;
                end
            end
        end
    end

    // result sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
        end else begin
            unique case (r_state)
                TS_IDLE: begin
                    if (w_start) begin
                        r_state <= TS_CALC;
                    end
                end
                TS_CALC: begin
                    if (w_div_done) begin
                        r_state <= TS_HOLD;
                    end
                end
                TS_HOLD: begin
                    if (w_out_load) begin
                        r_state <= TS_IDLE;
                    end
                end
                default: r_state <= TS_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_mag <= w_div_mag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_magnitude = r_mag;

    // serial arithmetic chain
    qrmrm_interp #(
        .INTERP_FACTOR (INTERP_FACTOR),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_d_i   (w_d_i),
        .i_d_q   (w_d_q),
        .i_p_i   (w_p_i),
        .i_p_q   (w_p_q),
        .i_frac  (r_frac),
        .o_done  (w_interp_done),
        .o_abs_i (w_abs_i),
        .o_abs_q (w_abs_q)
    );

    qrmrm_sqrt #(
        .AW (NW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_interp_done),
        .i_a_i   (w_abs_i),
        .i_a_q   (w_abs_q),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    qrmrm_div #(
        .NUM_W   (RW),
        .DIVISOR (DIVISOR)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_done),
        .i_num   (w_root),
        .o_done  (w_div_done),
        .o_mag   (w_div_mag)
    );

    // checks
    `QRMRM_ASSERT_NOW(a_out_idx_range, 1'b1, r_out_idx <= K_LAST, "output index past cycle")
    `QRMRM_ASSERT_NOW(a_next_pos_range, 1'b1, r_next_pos <= NPW'(DECIM_FACTOR), "bad output position")
    `QRMRM_ASSERT_NEXT(a_start_calc, w_start, r_state == TS_CALC, "start did not enter calc")
    `QRMRM_ASSERT_NOW(a_done_in_calc, w_div_done, r_state == TS_CALC, "divide done outside calc")

endmodule

// ===== tb/magnitude_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnitude_checker
// Watches both channels of the quarter rate mix resample magnitude unit.
// Every input transfer advances a private copy of the mixer and resampler
// state; when that transfer lands on an output slot of the frame, the
// expected magnitude is queued. Each output transfer is compared with the
// oldest queued magnitude, and failures are counted for the top.
// ----------------------------------------------------------------------------
module magnitude_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_stall,
    input  logic signed [qrmrm_pkg::DEF_SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [qrmrm_pkg::DEF_SAMPLE_WIDTH-1:0] i_sample_q,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_stall,
    input  logic [qrmrm_pkg::MAG_WIDTH-1:0]           i_magnitude,
    output int                                        o_errors,
    output int                                        o_pending,
    output int                                        o_checked
);
    import qrmrm_pkg::*;

    localparam int SW     = DEF_SAMPLE_WIDTH;
    localparam int L_FAC  = DEF_INTERP_FACTOR;
    localparam int M_FAC  = DEF_DECIM_FACTOR;
    localparam int SCALE  = (M_FAC / L_FAC == 0) ? 1 : M_FAC / L_FAC;

    // mixer and resampler state
    logic [1:0]           rot_phase;
    logic signed [SW-1:0] last_i;
    logic signed [SW-1:0] last_q;
    int unsigned          frame_pos;
    int unsigned          slot_idx;

    // magnitudes still owed by the block, oldest first
    logic [MAG_WIDTH-1:0] owed_mags[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    // quarter-rate rotation: identity, -j, negate, +j
    function automatic void rotate(input logic [1:0] phase, input longint re,
                                   input longint im, output longint oi,
                                   output longint oq);
        case (phase)
            2'd0: begin oi = re;  oq = im;  end
            2'd1: begin oi = im;  oq = -re; end
            2'd2: begin oi = -re; oq = -im; end
            default: begin oi = -im; oq = re; end
        endcase
    endfunction

    // floor of the square root, one result bit per pass
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // advance the frame by one sample and queue a magnitude when one is due
    function automatic void advance_frame(input logic signed [SW-1:0] si,
                                          input logic signed [SW-1:0] sq);
        longint          di, dq, pi, pq, ni, nq;
        longint          frac;
        longint unsigned ai, aq, mag;
        logic [1:0]      prev_phase;
        prev_phase = rot_phase - 2'd1;
        rotate(rot_phase, longint'(si), longint'(sq), di, dq);
        rotate(prev_phase, longint'(last_i), longint'(last_q), pi, pq);

        if (slot_idx < L_FAC && (slot_idx * M_FAC) / L_FAC <= frame_pos) begin
            frac = longint'((slot_idx * M_FAC) % L_FAC);
            // interpolation kept scaled by L to stay exact
            ni  = L_FAC * di + (di - pi) * frac;
            nq  = L_FAC * dq + (dq - pq) * frac;
            ai  = (ni < 0) ? -ni : ni;
            aq  = (nq < 0) ? -nq : nq;
            mag = floor_root(ai * ai + aq * aq) / (L_FAC * SCALE);
            if (mag > MAG_MAX)
                mag = MAG_MAX;
            owed_mags.push_back(MAG_WIDTH'(mag));
            slot_idx++;
        end

        last_i    = si;
        last_q    = sq;
        rot_phase = rot_phase + 2'd1;
        frame_pos++;
        if (frame_pos >= M_FAC) begin
            frame_pos = 0;
            slot_idx  = 0;
        end
    endfunction

    // compare output transfers, then predict from input transfers
    always @(posedge i_clk) begin : watch
        logic [MAG_WIDTH-1:0] want;
        if (!i_rst_n) begin
            rot_phase = '0;
            last_i    = '0;
            last_q    = '0;
            frame_pos = 0;
            slot_idx  = 0;
            owed_mags.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_mags.size() == 0) begin
                    $error("magnitude: no result expected, actual %0d", i_magnitude);
                    o_errors++;
                end else begin
                    want = owed_mags.pop_front();
                    o_checked++;
                    if (i_magnitude !== want) begin
                        $error("magnitude: expected %0d, actual %0d", want, i_magnitude);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                advance_frame(i_sample_i, i_sample_q);
        end
        o_pending = owed_mags.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the quarter rate mix resample magnitude unit.
// A short directed burst of full-scale and corner samples is followed by
// random I/Q samples biased toward the extremes, spanning several resampling
// frames. Both channels idle and stall at random, with calm stretches. The
// checker predicts and compares; this module reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;
    import qrmrm_pkg::*;

    localparam int SW             = DEF_SAMPLE_WIDTH;
    localparam int N_SAMPLES      = 1600;
    localparam int N_DIRECTED     = 24;
    localparam int IDLE_MAX       = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic signed [SW-1:0] sample_i  = '0;
    logic signed [SW-1:0] sample_q  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [MAG_WIDTH-1:0] magnitude;

    int errors;
    int pending;
    int checked;
    bit calm = 1'b0;

    // corner samples: every rotation phase sees full scale, and the pair
    // feeding the second output of the frame gives the widest step
    logic [SW-1:0] dir_i[N_DIRECTED] = '{
        16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff,
        16'h0001, 16'h0000, 16'h8000, 16'hffff, 16'h0000, 16'h4000,
        16'h5555, 16'haaaa, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
        16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h8001
    };
    logic [SW-1:0] dir_q[N_DIRECTED] = '{
        16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'hffff,
        16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'hffff, 16'hbfff,
        16'haaaa, 16'h5555, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
        16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h8001, 16'hffff
    };

    quarter_rate_mix_resample_magnitude_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample_i  (sample_i),
        .i_sample_q  (sample_q),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_magnitude (magnitude)
    );

    magnitude_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_sample_i  (sample_i),
        .i_sample_q  (sample_q),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_magnitude (magnitude),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // clock and reset
    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // per-transfer wait, zero throughout a calm stretch
    function automatic int idle_cycles();
        return calm ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // random component, leaning on full scale and zero
    function automatic logic [SW-1:0] pick_component();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(SW-1){1'b0}}};
            1: return {1'b0, {(SW-1){1'b1}}};
            2: return '0;
            3: return '1;
            4: return SW'($urandom_range(0, 255));
            5: return ~SW'($urandom_range(0, 255));
            default: return SW'($urandom);
        endcase
    endfunction

    // one input transfer, with a random gap before it
    task automatic send_sample(input logic [SW-1:0] si, input logic [SW-1:0] sq);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_i <= si;
        sample_q <= sq;
        do @(posedge clk); while (in_stall);
    endtask

    // result side: stall for a drawn number of valid cycles, then take it
    initial begin : result_sink
        int hold;
        @(posedge rst_n);
        forever begin
            hold = idle_cycles();
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                while (hold > 0) begin
                    @(posedge clk);
                    if (out_valid)
                        hold--;
                end
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d idle cycles, %0d results owed", quiet, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [SW-1:0] ri, rq;
        @(posedge rst_n);

        // directed corners
        for (int n = 0; n < N_DIRECTED; n++)
            send_sample(dir_i[n], dir_q[n]);

        // held or inverted draws start from the last corner sample
        ri = dir_i[N_DIRECTED-1];
        rq = dir_q[N_DIRECTED-1];

        // random samples; sometimes held or bit-inverted to mimic slow tones
        for (int n = N_DIRECTED; n < N_SAMPLES; n++) begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0: ;
                1: begin ri = ~ri; rq = ~rq; end
                default: begin ri = pick_component(); rq = pick_component(); end
            endcase
            send_sample(ri, rq);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // drain the results still owed, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d I/Q samples over %0d resampling frames, %0d magnitudes compared",
                 N_SAMPLES, (N_SAMPLES + DEF_DECIM_FACTOR - 1) / DEF_DECIM_FACTOR, checked);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
